### rtl/assert_macros.svh
// Assertion macros used by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MDPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Plain invariant.
`define MDPC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

### rtl/mdpc_pkg.sv
// Package with the types and constants of the minimum distance pixel classifier.
package mdpc_pkg;

   localparam int DEFAULT_MAX_CLASSES = 16;
   localparam int DEFAULT_BANDS       = 4;
   localparam int MAX_BANDS           = 4;
   localparam int BAND_W              = 8;
   localparam int SQ_W                = 2 * BAND_W;
   localparam int CODE_W              = 8;
   localparam int DIST_W              = 18;
   localparam int SLOT_W              = 4;
   localparam int CLASSES_W           = 5;
   localparam int BANDS_W             = 3;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [DIST_W-1:0]    RESET_THRESHOLD_SQUARED = {DIST_W{1'b1}};
   localparam logic [CLASSES_W-1:0] RESET_ACTIVE_CLASSES    = '0;
   localparam logic [BANDS_W-1:0]   RESET_ACTIVE_BANDS      = BANDS_W'(MAX_BANDS);

   typedef enum logic [1:0] {
      REG_THRESHOLD_ENABLE  = 2'd0,
      REG_THRESHOLD_SQUARED = 2'd1,
      REG_ACTIVE_CLASSES    = 2'd2,
      REG_ACTIVE_BANDS      = 2'd3
   } reg_index_type;

   typedef logic [MAX_BANDS-1:0][BAND_W-1:0] band_vec_type;

   typedef struct packed {
      logic                 threshold_enable;
      logic [DIST_W-1:0]    threshold_squared;
      logic [CLASSES_W-1:0] active_classes;
      logic [BANDS_W-1:0]   active_bands;
   } cfg_type;

   typedef struct packed {
      band_vec_type        pixel;
      logic                found;
      logic [DIST_W-1:0]   best;
      logic [CODE_W-1:0]   code;
   } token_type;

endpackage

### rtl/mdpc_cell.sv
// One class slot of the chain: stores a slot, scores the passing pixel item.
module mdpc_cell import mdpc_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int BANDS      = DEFAULT_BANDS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cfg_type           cfg,
   input  logic              load_en,
   input  logic [CODE_W-1:0] load_code,
   input  band_vec_type      load_means,
   input  logic              prev_valid,
   input  token_type         prev_tok,
   output logic              next_valid,
   output token_type         next_tok
);

   logic [CODE_W-1:0]             code_ff;
   logic [BANDS-1:0][BAND_W-1:0]  means_ff;
   logic [BANDS-1:0][BAND_W-1:0]  diff;
   logic [BANDS-1:0][SQ_W-1:0]    sq;
   logic [DIST_W-1:0]             sq_sum;
   logic                          active;
   logic                          qualify;
   logic                          tok_valid_ff;
   token_type                     tok_ff;
   token_type                     tok_in;

   always_ff @(posedge clock) begin
      if (load_en) begin
         code_ff <= load_code;
         for (int b = 0; b < BANDS; b++) begin
            means_ff[b] <= load_means[b];
         end
      end
   end

   always_comb begin
      for (int b = 0; b < BANDS; b++) begin
         diff[b] = (prev_tok.pixel[b] >= means_ff[b]) ? prev_tok.pixel[b] - means_ff[b]
                                                      : means_ff[b] - prev_tok.pixel[b];
         sq[b]   = (b < int'(cfg.active_bands)) ? SQ_W'(diff[b] * diff[b]) : '0;
      end
   end

   always_comb begin
      sq_sum = '0;
      for (int b = 0; b < BANDS; b++) begin
         sq_sum = sq_sum + DIST_W'(sq[b]);
      end
   end

   assign active  = (CELL_INDEX < int'(cfg.active_classes));
   assign qualify = prev_valid && active
                    && (!prev_tok.found || (sq_sum < prev_tok.best))
                    && (!cfg.threshold_enable || (sq_sum < cfg.threshold_squared));

   always_comb begin
      tok_in = prev_tok;
      if (qualify) begin
         tok_in.found = 1'b1;
         tok_in.best  = sq_sum;
         tok_in.code  = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (advance) begin
         tok_valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign next_valid = tok_valid_ff;
   assign next_tok   = tok_ff;

endmodule

### rtl/mdpc_csr.sv
// Configuration registers of the classifier behind an APB-style port.
module mdpc_csr import mdpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_enable  <= 1'b0;
         cfg_ff.threshold_squared <= RESET_THRESHOLD_SQUARED;
         cfg_ff.active_classes    <= RESET_ACTIVE_CLASSES;
         cfg_ff.active_bands      <= RESET_ACTIVE_BANDS;
      end else if (wr_en) begin
         case (reg_index)
            REG_THRESHOLD_ENABLE:  cfg_ff.threshold_enable  <= pwdata[0];
            REG_THRESHOLD_SQUARED: cfg_ff.threshold_squared <= pwdata[DIST_W-1:0];
            REG_ACTIVE_CLASSES:    cfg_ff.active_classes    <= pwdata[CLASSES_W-1:0];
            REG_ACTIVE_BANDS:      cfg_ff.active_bands      <= pwdata[BANDS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_THRESHOLD_ENABLE:  prdata = CSR_DATA_W'(cfg_ff.threshold_enable);
         REG_THRESHOLD_SQUARED: prdata = CSR_DATA_W'(cfg_ff.threshold_squared);
         REG_ACTIVE_CLASSES:    prdata = CSR_DATA_W'(cfg_ff.active_classes);
         REG_ACTIVE_BANDS:      prdata = CSR_DATA_W'(cfg_ff.active_bands);
         default:               prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/min_distance_pixel_classifier_unit.sv
// Top level of the minimum distance pixel classifier: chain of slot cells.
//
// Input channel req_*: an item is taken when req_valid is high and req_stall
// low. A load item (opcode 0) writes one class slot (code and band means); a
// slot index at or above MAX_CLASSES is dropped. A classify item (opcode 1)
// enters the chain of MAX_CLASSES cells, one cell per class slot, and moves
// one cell per cycle while the chain is not held, keeping the nearest
// qualifying class so far. Result channel rsp_*: one item per classify item,
// registered in the output register when the item leaves the last cell. One
// classify item is in the chain at a time, so a new item is taken only after
// the previous one has left the chain.
// req_stall is high while an item is in the chain. When the receiver stalls,
// the finished result waits in the output register and the chain holds once
// its item reaches the last cell.
// Reset clears the chain and output valid flags and the configuration
// registers; slot contents stay undefined until loaded.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12. The user
// writes them only while the block is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module min_distance_pixel_classifier_unit import mdpc_pkg::*; #(
   parameter int MAX_CLASSES = DEFAULT_MAX_CLASSES,
   parameter int BANDS       = DEFAULT_BANDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [SLOT_W-1:0]     req_slot_index,
   input  logic [CODE_W-1:0]     req_slot_class_code,
   input  logic [BAND_W-1:0]     req_mean_band0,
   input  logic [BAND_W-1:0]     req_mean_band1,
   input  logic [BAND_W-1:0]     req_mean_band2,
   input  logic [BAND_W-1:0]     req_mean_band3,
   input  logic [BAND_W-1:0]     req_pixel_band0,
   input  logic [BAND_W-1:0]     req_pixel_band1,
   input  logic [BAND_W-1:0]     req_pixel_band2,
   input  logic [BAND_W-1:0]     req_pixel_band3,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_class_code,
   output logic                  rsp_matched,
   output logic [DIST_W-1:0]     rsp_best_distance,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type                  cfg;
   logic                     req_accept;
   logic                     load_accept;
   logic                     classify_accept;
   logic                     advance;
   logic                     chain_done;
   logic                     busy_ff;
   logic                     busy_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [CODE_W-1:0]        rsp_class_code_ff;
   logic                     rsp_matched_ff;
   logic [DIST_W-1:0]        rsp_best_distance_ff;
   band_vec_type             load_means;
   logic [MAX_CLASSES:0]     chain_valid;
   token_type                chain_tok [MAX_CLASSES+1];

   mdpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall       = busy_ff;
   assign req_accept      = req_valid && !req_stall;
   assign load_accept     = req_accept && (req_opcode == OP_LOAD);
   assign classify_accept = req_accept && (req_opcode == OP_CLASSIFY);

   assign advance    = !(chain_valid[MAX_CLASSES] && rsp_valid_ff && rsp_stall);
   assign chain_done = chain_valid[MAX_CLASSES] && advance;

   assign load_means = {req_mean_band3, req_mean_band2, req_mean_band1, req_mean_band0};

   assign chain_valid[0]      = classify_accept;
   assign chain_tok[0].pixel  = {req_pixel_band3, req_pixel_band2,
                                 req_pixel_band1, req_pixel_band0};
   assign chain_tok[0].found  = 1'b0;
   assign chain_tok[0].best   = '0;
   assign chain_tok[0].code   = '0;

   for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
      mdpc_cell #(
         .CELL_INDEX (i),
         .BANDS      (BANDS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cfg        (cfg),
         .load_en    (load_accept && (int'(req_slot_index) == i)),
         .load_code  (req_slot_class_code),
         .load_means (load_means),
         .prev_valid (chain_valid[i]),
         .prev_tok   (chain_tok[i]),
         .next_valid (chain_valid[i+1]),
         .next_tok   (chain_tok[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (classify_accept) begin
         busy_in = 1'b1;
      end else if (chain_done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (chain_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_done) begin
         rsp_class_code_ff    <= chain_tok[MAX_CLASSES].code;
         rsp_matched_ff       <= chain_tok[MAX_CLASSES].found;
         rsp_best_distance_ff <= chain_tok[MAX_CLASSES].best;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_code    = rsp_class_code_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_best_distance = rsp_best_distance_ff;

   `MDPC_ASSERT_ALWAYS(a_one_item_in_chain, clock, reset, $onehot0(chain_valid[MAX_CLASSES:1]), "more than one item in the chain")
   `MDPC_ASSERT_IMPL(a_idle_chain_empty, clock, reset, !busy_ff, chain_valid[MAX_CLASSES:1] == '0, "item in chain while idle")
   `MDPC_ASSERT_NEXT(a_classify_busy, clock, reset, classify_accept, busy_ff, "classify item did not mark busy")
   `MDPC_ASSERT_IMPL(a_no_match_zero, clock, reset, rsp_valid && !rsp_matched, (rsp_class_code == '0) && (rsp_best_distance == '0), "unmatched result not zero")

endmodule

### tb/tb_mdpc_scoreboard.sv
// Item types and the nearest-class scoreboard for the minimum distance pixel classifier.
`timescale 1ns / 1ps
package tb_mdpc_pkg;
   import mdpc_pkg::*;

   localparam int SLOT_COUNT   = DEFAULT_MAX_CLASSES;
   localparam int BAND_COUNT   = DEFAULT_BANDS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] slot_index;
      logic [CODE_W-1:0] slot_class_code;
      band_vec_type      means;
      band_vec_type      pixel;
   } pixel_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] class_code;
      logic              matched;
      logic [DIST_W-1:0] best_distance;
   } class_result_type;

   class classification_scoreboard;
      logic [CODE_W-1:0]    slot_code [SLOT_COUNT];
      band_vec_type         slot_means [SLOT_COUNT];
      logic                 threshold_enable;
      logic [DIST_W-1:0]    threshold_squared;
      logic [CLASSES_W-1:0] active_classes;
      logic [BANDS_W-1:0]   active_bands;
      class_result_type     expected_classes[$];
      int unsigned          mismatches;
      int unsigned          results_checked;
      int unsigned          loads_seen;
      int unsigned          pixels_seen;

      function new();
         foreach (slot_code[s]) begin
            slot_code[s]  = '0;
            slot_means[s] = '0;
         end
         threshold_enable  = 1'b0;
         threshold_squared = RESET_THRESHOLD_SQUARED;
         active_classes    = RESET_ACTIVE_CLASSES;
         active_bands      = RESET_ACTIVE_BANDS;
         mismatches        = 0;
         results_checked   = 0;
         loads_seen        = 0;
         pixels_seen       = 0;
      endfunction

      function void write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_THRESHOLD_ENABLE:  threshold_enable  = value[0];
            REG_THRESHOLD_SQUARED: threshold_squared = value[DIST_W-1:0];
            REG_ACTIVE_CLASSES:    active_classes    = value[CLASSES_W-1:0];
            REG_ACTIVE_BANDS:      active_bands      = value[BANDS_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned searched_classes();
         return (active_classes > SLOT_COUNT) ? SLOT_COUNT : int'(active_classes);
      endfunction

      function class_result_type nearest_class(band_vec_type pixel);
         class_result_type r;
         int unsigned      nb, sq_sum, best, d;
         bit               found;
         logic [CODE_W-1:0] code;
         nb    = (active_bands > BAND_COUNT) ? BAND_COUNT : int'(active_bands);
         found = 1'b0;
         best  = 0;
         code  = '0;
         for (int s = 0; s < searched_classes(); s++) begin
            sq_sum = 0;
            for (int b = 0; b < nb; b++) begin
               if (pixel[b] >= slot_means[s][b]) d = pixel[b] - slot_means[s][b];
               else d = slot_means[s][b] - pixel[b];
               sq_sum += d * d;
            end
            if ((!found || sq_sum < best) &&
                (!threshold_enable || sq_sum < threshold_squared)) begin
               found = 1'b1;
               best  = sq_sum;
               code  = slot_code[s];
            end
         end
         r.class_code    = found ? code : '0;
         r.matched       = found;
         r.best_distance = found ? best[DIST_W-1:0] : '0;
         return r;
      endfunction

      function void note_item(pixel_item_type item);
         if (item.opcode == OP_LOAD) begin
            loads_seen++;
            slot_code[item.slot_index]  = item.slot_class_code;
            slot_means[item.slot_index] = item.means;
         end else begin
            pixels_seen++;
            expected_classes.push_back(nearest_class(item.pixel));
         end
      endfunction

      function void check_result(class_result_type got);
         class_result_type exp;
         results_checked++;
         if (expected_classes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: code %0d matched %0b distance %0d",
                        got.class_code, got.matched, got.best_distance);
            return;
         end
         exp = expected_classes.pop_front();
         if (got.class_code !== exp.class_code || got.matched !== exp.matched ||
             got.best_distance !== exp.best_distance) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: expected code %0d matched %0b distance %0d, got code %0d matched %0b distance %0d",
                        results_checked, exp.class_code, exp.matched, exp.best_distance,
                        got.class_code, got.matched, got.best_distance);
         end
      endfunction

      function int unsigned pending();
         return expected_classes.size();
      endfunction
   endclass

endpackage

### tb/tb_top.sv
// Top-level testbench of the minimum distance pixel classifier unit.
`timescale 1ns / 1ps
module tb_top import mdpc_pkg::*, tb_mdpc_pkg::*;;

   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 135;
   localparam int SETTLE_CYCLES    = DEFAULT_MAX_CLASSES + 4;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int HOLD_AT_RESULT   = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_LOAD;
   logic [SLOT_W-1:0]     req_slot_index = '0;
   logic [CODE_W-1:0]     req_slot_class_code = '0;
   logic [BAND_W-1:0]     req_mean_band0 = '0;
   logic [BAND_W-1:0]     req_mean_band1 = '0;
   logic [BAND_W-1:0]     req_mean_band2 = '0;
   logic [BAND_W-1:0]     req_mean_band3 = '0;
   logic [BAND_W-1:0]     req_pixel_band0 = '0;
   logic [BAND_W-1:0]     req_pixel_band1 = '0;
   logic [BAND_W-1:0]     req_pixel_band2 = '0;
   logic [BAND_W-1:0]     req_pixel_band3 = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_class_code;
   logic                  rsp_matched;
   logic [DIST_W-1:0]     rsp_best_distance;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   classification_scoreboard sb;
   bit                       no_idle = 1'b0;
   int unsigned              settings_used = 0;
   int unsigned              quiet_cycles = 0;

   min_distance_pixel_classifier_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_slot_index      (req_slot_index),
      .req_slot_class_code (req_slot_class_code),
      .req_mean_band0      (req_mean_band0),
      .req_mean_band1      (req_mean_band1),
      .req_mean_band2      (req_mean_band2),
      .req_mean_band3      (req_mean_band3),
      .req_pixel_band0     (req_pixel_band0),
      .req_pixel_band1     (req_pixel_band1),
      .req_pixel_band2     (req_pixel_band2),
      .req_pixel_band3     (req_pixel_band3),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_class_code      (rsp_class_code),
      .rsp_matched         (rsp_matched),
      .rsp_best_distance   (rsp_best_distance),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [BAND_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return BAND_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic band_vec_type rand_bands();
      band_vec_type v;
      for (int b = 0; b < MAX_BANDS; b++) v[b] = rand_byte();
      return v;
   endfunction

   function automatic pixel_item_type load_item(logic [SLOT_W-1:0] slot,
                                                logic [CODE_W-1:0] code,
                                                band_vec_type means);
      pixel_item_type item;
      item.opcode          = OP_LOAD;
      item.slot_index      = slot;
      item.slot_class_code = code;
      item.means           = means;
      item.pixel           = rand_bands();
      return item;
   endfunction

   function automatic pixel_item_type classify_item(band_vec_type pixel);
      pixel_item_type item;
      item.opcode          = OP_CLASSIFY;
      item.slot_index      = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      item.slot_class_code = rand_byte();
      item.means           = rand_bands();
      item.pixel           = pixel;
      return item;
   endfunction

   task automatic send_item(pixel_item_type item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= item.opcode;
      req_slot_index      <= item.slot_index;
      req_slot_class_code <= item.slot_class_code;
      req_mean_band0      <= item.means[0];
      req_mean_band1      <= item.means[1];
      req_mean_band2      <= item.means[2];
      req_mean_band3      <= item.means[3];
      req_pixel_band0     <= item.pixel[0];
      req_pixel_band1     <= item.pixel[1];
      req_pixel_band2     <= item.pixel[2];
      req_pixel_band3     <= item.pixel[3];
      do @(posedge clock); while (req_stall);
      sb.note_item(item);
   endtask

   task automatic send_random_item();
      pixel_item_type item;
      band_vec_type   v;
      int unsigned    s, span, reach;
      int             val;
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 3) == 0) v = sb.slot_means[$urandom_range(0, SLOT_COUNT - 1)];
         else v = rand_bands();
         item = load_item(SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), rand_byte(), v);
      end else if ($urandom_range(0, 1) == 0) begin
         span = sb.searched_classes();
         if (span == 0) span = SLOT_COUNT;
         s = $urandom_range(0, span - 1);
         case ($urandom_range(0, 2))
            0: reach = 0;
            1: reach = 3;
            default: reach = 20;
         endcase
         for (int b = 0; b < MAX_BANDS; b++) begin
            val = int'(sb.slot_means[s][b]) + int'($urandom_range(0, 2 * reach)) - int'(reach);
            if (val < 0) val = 0;
            if (val > 255) val = 255;
            v[b] = val[BAND_W-1:0];
         end
         item = classify_item(v);
      end else begin
         item = classify_item(rand_bands());
      end
      send_item(item);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic en, logic [DIST_W-1:0] thr,
                            logic [CLASSES_W-1:0] cls, logic [BANDS_W-1:0] nb);
      wait_idle();
      write_register(REG_THRESHOLD_ENABLE, CSR_DATA_W'(en));
      write_register(REG_THRESHOLD_SQUARED, CSR_DATA_W'(thr));
      write_register(REG_ACTIVE_CLASSES, CSR_DATA_W'(cls));
      write_register(REG_ACTIVE_BANDS, CSR_DATA_W'(nb));
      settings_used++;
   endtask

   // receiver: random stalls, one long hold-off to back up the chain
   initial begin
      int unsigned      gap;
      bit               held;
      class_result_type got;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!held && sb.results_checked == HOLD_AT_RESULT) begin
            held = 1'b1;
            gap  = HOLD_OFF_CYCLES;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.class_code    = rsp_class_code;
         got.matched       = rsp_matched;
         got.best_distance = rsp_best_distance;
         sb.check_result(got);
      end
   end

   initial begin
      logic                 en;
      logic [DIST_W-1:0]    thr;
      logic [CLASSES_W-1:0] cls;
      logic [BANDS_W-1:0]   nb;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no classes searched yet; load every slot
      send_item(classify_item({4{8'h00}}));
      send_item(classify_item({4{8'hFF}}));
      send_item(load_item(4'd0, 8'hFF, {4{8'h00}}));
      send_item(load_item(4'd1, 8'h01, {4{8'h00}}));
      send_item(load_item(4'd2, 8'h00, {4{8'hFF}}));
      send_item(load_item(4'd3, 8'hAA, {8'hFF, 8'h00, 8'hFF, 8'h00}));
      for (int s = 4; s < SLOT_COUNT; s++)
         send_item(load_item(SLOT_W'(s), rand_byte(), rand_bands()));

      configure(1'b0, RESET_THRESHOLD_SQUARED, CLASSES_W'(SLOT_COUNT), BANDS_W'(BAND_COUNT));
      send_item(classify_item({4{8'hFF}}));
      send_item(classify_item({4{8'h00}}));
      send_item(classify_item({8'h00, 8'hFF, 8'h00, 8'hFF}));

      configure(1'b1, DIST_W'(260101), CLASSES_W'(1), BANDS_W'(BAND_COUNT));
      send_item(classify_item({4{8'hFF}}));

      configure(1'b1, '0, CLASSES_W'(31), '0);
      send_item(classify_item(rand_bands()));

      configure(1'b1, DIST_W'(1), CLASSES_W'(17), BANDS_W'(7));
      send_item(classify_item({4{8'h00}}));

      configure(1'b0, '0, CLASSES_W'(SLOT_COUNT), '0);
      send_item(classify_item(rand_bands()));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         en = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 4))
            0: thr = '0;
            1: thr = RESET_THRESHOLD_SQUARED;
            2: thr = DIST_W'($urandom_range(0, 262143));
            3: thr = DIST_W'($urandom_range(0, 2000));
            default: thr = DIST_W'($urandom_range(10000, 90000));
         endcase
         case ($urandom_range(0, 3))
            0: cls = CLASSES_W'($urandom_range(17, 31));
            1: cls = CLASSES_W'($urandom_range(0, 3));
            default: cls = CLASSES_W'($urandom_range(4, SLOT_COUNT));
         endcase
         case ($urandom_range(0, 3))
            0: nb = BANDS_W'($urandom_range(0, 7));
            1: nb = BANDS_W'($urandom_range(1, 3));
            default: nb = BANDS_W'(BAND_COUNT);
         endcase
         if (phase == 0) begin
            en  = 1'b0;
            cls = CLASSES_W'(SLOT_COUNT);
            nb  = BANDS_W'(BAND_COUNT);
         end
         configure(en, thr, cls, nb);
         no_idle = (phase % 3 == 2);
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      no_idle = 1'b0;
      wait_idle();
      $display("Sent %0d items: %0d slot loads, %0d pixels, over %0d register settings.",
               sb.loads_seen + sb.pixels_seen, sb.loads_seen, sb.pixels_seen, settings_used);
      $display("Checked %0d classification results, %0d mismatches, %0d still expected.",
               sb.results_checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
